// ===== rtl/idwl_pkg.sv =====
package idwl_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned UID_W       = 32;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PC_W        = 5;

  localparam logic [UID_W-1:0] ZERO_ID = 32'h0000_0000;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_ZERO = 3'd1,
    ST_DUP  = 3'd2,
    ST_FULL = 3'd3,
    ST_MISS = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_UID_ZERO,
    C_CNT_ZERO,
    C_MATCH,
    C_STOP,
    C_HIT,
    C_NO_ZERO,
    C_IDX_EQ_CNT
  } cond_e;

  typedef enum logic [1:0] {
    LOOP_NONE,
    LOOP_ALL,
    LOOP_LIVE
  } loop_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZSLOT,
    WR_SHIFT,
    WR_CLR_LAST
  } wr_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  typedef struct packed {
    logic            dispatch;
    cond_e           cond;
    logic [PC_W-1:0] target;
    loop_e           loop_sel;
    idx_op_e         idx_op;
    logic            note_zero;
    wr_e             wr;
    cnt_op_e         cnt_op;
    logic            clr_all;
    logic            done;
    status_e         status;
    logic            acc;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t cw;
    logic       en;
    logic       loop_stay;
  } dp_ctrl_t;

  typedef struct packed {
    logic uid_zero;
    logic rd_zero;
    logic match;
    logic hit;
    logic cnt_zero;
    logic no_zero;
    logic idx_eq_cnt;
    logic end_all;
    logic end_live;
  } dp_flags_t;

  // program step addresses
  localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] S_A0      = 5'd1;
  localparam logic [PC_W-1:0] S_A1      = 5'd2;
  localparam logic [PC_W-1:0] S_A2      = 5'd3;
  localparam logic [PC_W-1:0] S_A3      = 5'd4;
  localparam logic [PC_W-1:0] S_R0      = 5'd5;
  localparam logic [PC_W-1:0] S_R1      = 5'd6;
  localparam logic [PC_W-1:0] S_R2      = 5'd7;
  localparam logic [PC_W-1:0] S_R3      = 5'd8;
  localparam logic [PC_W-1:0] S_R4      = 5'd9;
  localparam logic [PC_W-1:0] S_R5      = 5'd10;
  localparam logic [PC_W-1:0] S_R6      = 5'd11;
  localparam logic [PC_W-1:0] S_R7      = 5'd12;
  localparam logic [PC_W-1:0] S_L0      = 5'd13;
  localparam logic [PC_W-1:0] S_L1      = 5'd14;
  localparam logic [PC_W-1:0] S_L2      = 5'd15;
  localparam logic [PC_W-1:0] S_F_MISS  = 5'd16;
  localparam logic [PC_W-1:0] S_F_ZERO  = 5'd17;
  localparam logic [PC_W-1:0] S_F_DUP   = 5'd18;
  localparam logic [PC_W-1:0] S_F_FULL  = 5'd19;
  localparam logic [PC_W-1:0] S_F_FOUND = 5'd20;
  localparam logic [PC_W-1:0] S_C0      = 5'd21;

  localparam ctrl_word_t CW_NOP = '{
    dispatch:  1'b0,
    cond:      C_NEVER,
    target:    S_IDLE,
    loop_sel:  LOOP_NONE,
    idx_op:    IDX_HOLD,
    note_zero: 1'b0,
    wr:        WR_NONE,
    cnt_op:    CNT_HOLD,
    clr_all:   1'b0,
    done:      1'b0,
    status:    ST_OK,
    acc:       1'b0
  };

  function automatic logic [PC_W-1:0] entry_pc(action_e act);
    logic [PC_W-1:0] pc;
    unique case (act)
      ACT_ADD:    pc = S_A0;
      ACT_REMOVE: pc = S_R0;
      ACT_LOOKUP: pc = S_L0;
      ACT_CLEAR:  pc = S_C0;
      default:    pc = S_IDLE;
    endcase
    return pc;
  endfunction

  function automatic ctrl_word_t ucode(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = CW_NOP;
    unique case (pc)
      S_IDLE: begin
        w.dispatch = 1'b1;
      end
      // add: reject zero, scan whole table for duplicate and first free slot
      S_A0: begin
        w.idx_op = IDX_CLR;
        w.cond   = C_UID_ZERO;
        w.target = S_F_ZERO;
      end
      S_A1: begin
        w.note_zero = 1'b1;
        w.cond      = C_MATCH;
        w.target    = S_F_DUP;
        w.loop_sel  = LOOP_ALL;
      end
      S_A2: begin
        w.cond   = C_NO_ZERO;
        w.target = S_F_FULL;
      end
      S_A3: begin
        w.wr     = WR_ZSLOT;
        w.cnt_op = CNT_INC;
        w.done   = 1'b1;
        w.status = ST_OK;
        w.acc    = 1'b1;
      end
      // remove: find among counted entries, shift down, clear last
      S_R0: begin
        w.idx_op = IDX_CLR;
        w.cond   = C_UID_ZERO;
        w.target = S_F_MISS;
      end
      S_R1: begin
        w.cond   = C_CNT_ZERO;
        w.target = S_F_MISS;
      end
      S_R2: begin
        w.cond     = C_MATCH;
        w.target   = S_R4;
        w.loop_sel = LOOP_LIVE;
      end
      S_R3: begin
        w.cond   = C_ALWAYS;
        w.target = S_F_MISS;
      end
      S_R4: begin
        w.idx_op = IDX_INC;
      end
      S_R5: begin
        w.cond   = C_IDX_EQ_CNT;
        w.target = S_R7;
      end
      S_R6: begin
        w.wr       = WR_SHIFT;
        w.loop_sel = LOOP_LIVE;
      end
      S_R7: begin
        w.wr     = WR_CLR_LAST;
        w.cnt_op = CNT_DEC;
        w.done   = 1'b1;
        w.status = ST_OK;
        w.acc    = 1'b1;
      end
      // lookup: scan counted entries, stop at a free entry or a match
      S_L0: begin
        w.idx_op = IDX_CLR;
        w.cond   = C_CNT_ZERO;
        w.target = S_F_MISS;
      end
      S_L1: begin
        w.cond     = C_STOP;
        w.target   = S_L2;
        w.loop_sel = LOOP_LIVE;
      end
      S_L2: begin
        w.cond   = C_HIT;
        w.target = S_F_FOUND;
      end
      S_F_MISS: begin
        w.done   = 1'b1;
        w.status = ST_MISS;
      end
      S_F_ZERO: begin
        w.done   = 1'b1;
        w.status = ST_ZERO;
      end
      S_F_DUP: begin
        w.done   = 1'b1;
        w.status = ST_DUP;
      end
      S_F_FULL: begin
        w.done   = 1'b1;
        w.status = ST_FULL;
      end
      S_F_FOUND: begin
        w.done   = 1'b1;
        w.status = ST_OK;
        w.acc    = 1'b1;
      end
      S_C0: begin
        w.clr_all = 1'b1;
        w.cnt_op  = CNT_CLR;
        w.done    = 1'b1;
        w.status  = ST_OK;
        w.acc     = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/idwl_seq.sv =====
module idwl_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  idwl_pkg::action_e   action_i,
  input  idwl_pkg::dp_flags_t flags_i,
  input  logic                out_busy_i,
  output idwl_pkg::dp_ctrl_t  ctrl_o,
  output logic                idle_o
);

  logic [idwl_pkg::PC_W-1:0] pc_q, pc_d;
  idwl_pkg::ctrl_word_t      cw;
  logic                      cond_true;
  logic                      at_end;
  logic                      en;
  logic                      loop_stay;

  assign cw = idwl_pkg::ucode(pc_q);

  always_comb begin
    unique case (cw.cond)
      idwl_pkg::C_NEVER:      cond_true = 1'b0;
      idwl_pkg::C_ALWAYS:     cond_true = 1'b1;
      idwl_pkg::C_UID_ZERO:   cond_true = flags_i.uid_zero;
      idwl_pkg::C_CNT_ZERO:   cond_true = flags_i.cnt_zero;
      idwl_pkg::C_MATCH:      cond_true = flags_i.match;
      idwl_pkg::C_STOP:       cond_true = flags_i.rd_zero | flags_i.match;
      idwl_pkg::C_HIT:        cond_true = flags_i.hit;
      idwl_pkg::C_NO_ZERO:    cond_true = flags_i.no_zero;
      idwl_pkg::C_IDX_EQ_CNT: cond_true = flags_i.idx_eq_cnt;
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.loop_sel)
      idwl_pkg::LOOP_ALL:  at_end = flags_i.end_all;
      idwl_pkg::LOOP_LIVE: at_end = flags_i.end_live;
      default:             at_end = 1'b1;
    endcase
  end

  // a finishing step waits while the result register is still occupied
  assign en = ~(cw.done & out_busy_i);

  always_comb begin
    pc_d      = pc_q;
    loop_stay = 1'b0;
    if (cw.dispatch) begin
      if (start_i) begin
        pc_d = idwl_pkg::entry_pc(action_i);
      end
    end else if (!en) begin
      pc_d = pc_q;
    end else if (cw.done) begin
      pc_d = idwl_pkg::S_IDLE;
    end else if (cond_true) begin
      pc_d = cw.target;
    end else if (!at_end) begin
      loop_stay = 1'b1;
    end else begin
      pc_d = pc_q + idwl_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= idwl_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.cw        = cw;
  assign ctrl_o.en        = en;
  assign ctrl_o.loop_stay = loop_stay;
  assign idle_o           = cw.dispatch;

endmodule

// ===== rtl/idwl_dp.sv =====
module idwl_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [idwl_pkg::UID_W-1:0]       uid_i,
  input  idwl_pkg::dp_ctrl_t               ctrl_i,
  output idwl_pkg::dp_flags_t              flags_o,
  output logic [idwl_pkg::CNT_W-1:0]       cnt_next_o
);

  logic [idwl_pkg::UID_W-1:0]       mem_q [idwl_pkg::TABLE_DEPTH];
  logic [idwl_pkg::TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [idwl_pkg::UID_W-1:0]       uid_q;
  logic [idwl_pkg::CNT_W-1:0]       idx_q, idx_d;
  logic [idwl_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [idwl_pkg::IDX_W-1:0]       zslot_q, zslot_d;
  logic                             zf_q, zf_d;

  logic [idwl_pkg::UID_W-1:0]       rd_data;
  logic                             idx_in_range;
  logic [idwl_pkg::CNT_W-1:0]       idx_m1;
  logic [idwl_pkg::CNT_W-1:0]       cnt_m1;
  logic [idwl_pkg::IDX_W-1:0]       waddr;
  logic [idwl_pkg::UID_W-1:0]       wdata;
  logic                             mem_we;
  idwl_pkg::ctrl_word_t             cw;
  logic                             en;

  assign cw     = ctrl_i.cw;
  assign en     = ctrl_i.en;
  assign idx_m1 = idx_q - idwl_pkg::CNT_W'(1);
  assign cnt_m1 = cnt_q - idwl_pkg::CNT_W'(1);

  // entries without a valid bit read as zero
  assign idx_in_range = idx_q < idwl_pkg::CNT_W'(idwl_pkg::TABLE_DEPTH);
  assign rd_data = (idx_in_range && valid_q[idx_q[idwl_pkg::IDX_W-1:0]])
                 ? mem_q[idx_q[idwl_pkg::IDX_W-1:0]] : idwl_pkg::ZERO_ID;

  assign flags_o.uid_zero   = uid_q == idwl_pkg::ZERO_ID;
  assign flags_o.rd_zero    = rd_data == idwl_pkg::ZERO_ID;
  assign flags_o.match      = rd_data == uid_q;
  assign flags_o.hit        = (rd_data == uid_q) && (rd_data != idwl_pkg::ZERO_ID);
  assign flags_o.cnt_zero   = cnt_q == '0;
  assign flags_o.no_zero    = ~zf_q;
  assign flags_o.idx_eq_cnt = idx_q == cnt_q;
  assign flags_o.end_all    = idx_q == idwl_pkg::CNT_W'(idwl_pkg::TABLE_DEPTH - 1);
  assign flags_o.end_live   = idx_q == cnt_m1;

  always_comb begin
    idx_d   = idx_q;
    zf_d    = zf_q;
    zslot_d = zslot_q;
    cnt_d   = cnt_q;
    if (en) begin
      if (cw.idx_op == idwl_pkg::IDX_CLR) begin
        idx_d = '0;
        zf_d  = 1'b0;
      end else if (cw.idx_op == idwl_pkg::IDX_INC || ctrl_i.loop_stay) begin
        idx_d = idx_q + idwl_pkg::CNT_W'(1);
      end
      // remember the first free slot seen during the add scan
      if (cw.note_zero && (rd_data == idwl_pkg::ZERO_ID) && !zf_q) begin
        zf_d    = 1'b1;
        zslot_d = idx_q[idwl_pkg::IDX_W-1:0];
      end
      unique case (cw.cnt_op)
        idwl_pkg::CNT_INC: begin
          if (cnt_q < idwl_pkg::CNT_W'(idwl_pkg::TABLE_DEPTH)) begin
            cnt_d = cnt_q + idwl_pkg::CNT_W'(1);
          end
        end
        idwl_pkg::CNT_DEC:  cnt_d = cnt_m1;
        idwl_pkg::CNT_CLR:  cnt_d = '0;
        default:            cnt_d = cnt_q;
      endcase
    end
  end

  always_comb begin
    waddr   = zslot_q;
    wdata   = uid_q;
    mem_we  = 1'b0;
    valid_d = valid_q;
    if (en) begin
      unique case (cw.wr)
        idwl_pkg::WR_ZSLOT: begin
          waddr  = zslot_q;
          wdata  = uid_q;
          mem_we = 1'b1;
          valid_d[zslot_q] = 1'b1;
        end
        idwl_pkg::WR_SHIFT: begin
          waddr  = idx_m1[idwl_pkg::IDX_W-1:0];
          wdata  = rd_data;
          mem_we = 1'b1;
          valid_d[idx_m1[idwl_pkg::IDX_W-1:0]] = 1'b1;
        end
        idwl_pkg::WR_CLR_LAST: begin
          valid_d[cnt_m1[idwl_pkg::IDX_W-1:0]] = 1'b0;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
      if (cw.clr_all) begin
        valid_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      zf_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      zf_q    <= zf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zslot_q <= zslot_d;
    if (start_i) begin
      uid_q <= uid_i;
    end
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
  end

  assign cnt_next_o = cnt_d;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= idwl_pkg::CNT_W'(idwl_pkg::TABLE_DEPTH))
    else $error("member count above table depth");

  a_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("occupied entries disagree with member count");

  a_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && cw.wr == idwl_pkg::WR_ZSLOT) |-> (zf_q && !valid_q[zslot_q]))
    else $error("add written without a free slot");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && cw.wr == idwl_pkg::WR_SHIFT) |-> (idx_q != '0 && idx_q < cnt_q))
    else $error("shift write outside counted entries");
`endif

endmodule

// ===== rtl/id_whitelist_table.sv =====
// id whitelist table: a dense set of up to 16 nonzero 32-bit card ids
// input items arrive on s_axis: tuser carries the action (add, remove, lookup,
// clear) and tdata the card id; one result item per input leaves on m_axis
// with the accepted flag, a status code and the member count after the action
// a small microcode program steps through the table one entry per cycle:
// clear takes 1 step, add up to 19 steps (full-table duplicate scan), lookup
// up to 19, remove up to 21 (scan to the match, shift later entries down)
// the result is registered; one item is worked on at a time, and
// s_axis_tready rises again in the same cycle that the result item turns valid
// a result waiting on a stalled receiver does not block the next input item;
// only the following result holds in its last step until the register frees
// reset clears all entry valid bits and the count, so the table starts empty
module id_whitelist_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] uid
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] accepted, [3:1] status, [8:4] member_count
);

  idwl_pkg::dp_ctrl_t               ctrl;
  idwl_pkg::dp_flags_t              flags;
  logic [idwl_pkg::CNT_W-1:0]       cnt_next;
  logic                             idle;
  logic                             start;
  logic                             out_busy;
  logic                             done_fire;

  logic                             m_valid_q;
  logic                             acc_q;
  idwl_pkg::status_e                status_q;
  logic [idwl_pkg::CNT_W-1:0]       count_q;

  // an item is taken only while the sequencer sits at its idle step
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid & idle;

  // result register still held by the receiver
  assign out_busy  = m_valid_q & ~m_axis_tready;
  assign done_fire = ctrl.cw.done & ctrl.en;

  idwl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .action_i   (idwl_pkg::action_e'(s_axis_tuser)),
    .flags_i    (flags),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  idwl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .uid_i      (s_axis_tdata),
    .ctrl_i     (ctrl),
    .flags_o    (flags),
    .cnt_next_o (cnt_next)
  );

  // output valid: set by a finishing step, dropped once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // result payload, count as it stands after the action
  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      acc_q    <= ctrl.cw.acc;
      status_q <= ctrl.cw.status;
      count_q  <= cnt_next;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, count_q, status_q, acc_q};

endmodule

// ===== tb/id_whitelist_table_tb.sv =====
`timescale 1ns / 100ps

module id_whitelist_table_tb;
  import idwl_pkg::*;

  localparam int unsigned RUN_LIMIT   = 400000;  // cycles before the run is called hung
  localparam int unsigned POOL_SIZE   = 24;      // a few more ids than slots, so the table fills
  localparam int unsigned PHASE_ITEMS = 384;
  localparam int unsigned SETTLE      = 30;      // covers the longest remove program
  localparam int unsigned MAX_REPORTS = 100;

  // one predicted result item: accepted flag, status code and member count
  typedef struct packed {
    logic       accepted;
    status_e    status;
    logic [4:0] members;
  } table_reply_t;

  // shadow of the card table: applies each accepted item and queues the reply it predicts
  class card_table_sb;
    logic [UID_W-1:0] ids [TABLE_DEPTH];
    int unsigned      members;
    table_reply_t     pending_replies [$];
    int unsigned      errors;

    function new();
      clear_table();
      errors = 0;
    endfunction

    function void clear_table();
      foreach (ids[k]) ids[k] = ZERO_ID;
      members = 0;
    endfunction

    function table_reply_t apply_action(action_e act, logic [UID_W-1:0] uid);
      table_reply_t r;
      int unsigned  live;
      int           hit;
      r.accepted = 1'b0;
      r.status   = ST_OK;
      live = (members < TABLE_DEPTH) ? members : TABLE_DEPTH;
      hit  = -1;
      case (act)
        ACT_ADD: begin
          if (uid == ZERO_ID) begin
            r.status = ST_ZERO;
          end else begin
            // duplicates are searched in every slot, not only the counted ones
            foreach (ids[k]) if (ids[k] == uid) hit = k;
            if (hit >= 0) begin
              r.status = ST_DUP;
            end else begin
              r.status = ST_FULL;
              for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (ids[k] == ZERO_ID) begin
                  ids[k] = uid;
                  if (members < TABLE_DEPTH) members++;
                  r.accepted = 1'b1;
                  r.status   = ST_OK;
                  break;
                end
              end
            end
          end
        end
        ACT_REMOVE: begin
          r.status = ST_MISS;
          if (uid != ZERO_ID) begin
            for (int k = 0; k < live; k++) begin
              if (ids[k] == uid) begin
                hit = k;
                break;
              end
            end
          end
          if (hit >= 0) begin
            // shift later entries down; past the top slot the read gives zero
            for (int j = hit; j < live; j++)
              ids[j] = (j + 1 < TABLE_DEPTH) ? ids[j+1] : ZERO_ID;
            ids[live-1] = ZERO_ID;
            members     = live - 1;
            r.accepted  = 1'b1;
            r.status    = ST_OK;
          end
        end
        ACT_LOOKUP: begin
          r.status = ST_MISS;
          for (int k = 0; k < live; k++) begin
            if (ids[k] == ZERO_ID) break;
            if (ids[k] == uid) begin
              r.accepted = 1'b1;
              r.status   = ST_OK;
              break;
            end
          end
        end
        default: begin
          clear_table();
          r.accepted = 1'b1;
          r.status   = ST_OK;
        end
      endcase
      r.members = 5'(members);
      return r;
    endfunction

    function void note_request(action_e act, logic [UID_W-1:0] uid);
      pending_replies.push_back(apply_action(act, uid));
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_reply(logic [15:0] data);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item with none expected, expected none, actual %h",
                   $time, data);
        return;
      end
      want = pending_replies.pop_front();
      if (data[0] !== want.accepted) flag("accepted", want.accepted, data[0]);
      if (data[3:1] !== want.status) flag("status", want.status, data[3:1]);
      if (data[8:4] !== want.members) flag("member_count", want.members, data[8:4]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] uid
  logic [1:0]  s_axis_tuser;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] accepted, [3:1] status, [8:4] member_count

  card_table_sb     sb;
  int unsigned      src_idle_pct;
  int unsigned      dst_idle_pct;
  int unsigned      rx_hold_cycles;
  int unsigned      cycle_count;
  logic [UID_W-1:0] id_pool [POOL_SIZE];

  id_whitelist_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hang guard: free-running cycle count
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off while rx_hold_cycles runs down
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready  = 1'b0;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // every result item handshake is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
  end

  // offer one item from the falling edge on, with random idle cycles first;
  // returns just after the rising edge that accepted it
  task automatic send_item(input action_e act, input logic [UID_W-1:0] uid);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = uid;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(act, uid);
  endtask

  // sender pause: nothing goes out until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic void refill_pool();
    foreach (id_pool[k]) id_pool[k] = $urandom;
    // keep the extreme ids in play
    id_pool[0] = 32'hFFFF_FFFF;
    id_pool[1] = 32'h0000_0001;
  endfunction

  // mostly add, remove and lookup on a small id pool so hits, duplicates and a
  // full table keep occurring; some zero ids and fresh random ids as noise
  task automatic send_random();
    int unsigned      pick;
    action_e          act;
    logic [UID_W-1:0] uid;
    pick = $urandom_range(99);
    if (pick < 42)      act = ACT_ADD;
    else if (pick < 68) act = ACT_REMOVE;
    else if (pick < 98) act = ACT_LOOKUP;
    else                act = ACT_CLEAR;
    pick = $urandom_range(99);
    if (pick < 6)       uid = ZERO_ID;
    else if (pick < 82) uid = id_pool[$urandom_range(POOL_SIZE - 1)];
    else                uid = $urandom;
    send_item(act, uid);
    if (act == ACT_CLEAR && $urandom_range(1) == 1) refill_pool();
  endtask

  initial begin
    logic [UID_W-1:0] fill_ids [TABLE_DEPTH];
    sb             = new();
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ACT_ADD;
    rx_hold_cycles = 0;
    src_idle_pct   = 12;
    dst_idle_pct   = 61;
    refill_pool();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: misses on an empty table, zero id, fill to full, duplicate
    // and full rejects, removes at both ends, zero lookup, clear
    send_item(ACT_LOOKUP, ZERO_ID);
    send_item(ACT_ADD, ZERO_ID);
    send_item(ACT_REMOVE, 32'h0000_0005);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k == 0)      fill_ids[k] = 32'hFFFF_FFFF;
      else if (k == 1) fill_ids[k] = 32'h0000_0001;
      else             fill_ids[k] = {4'(k), 28'h5A5_A5A5};
      send_item(ACT_ADD, fill_ids[k]);
    end
    send_item(ACT_ADD, 32'h0000_0001);
    send_item(ACT_ADD, 32'h1234_5678);
    // remove the entry in the top slot, so nothing is left to shift down
    send_item(ACT_REMOVE, fill_ids[TABLE_DEPTH-1]);
    send_item(ACT_REMOVE, 32'hFFFF_FFFF);
    send_item(ACT_REMOVE, ZERO_ID);
    send_item(ACT_LOOKUP, ZERO_ID);
    send_item(ACT_LOOKUP, 32'h0000_0001);
    send_item(ACT_CLEAR, 32'hDEAD_BEEF);
    wait_drained();

    // three random phases: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 61 : 0;
      dst_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 12 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while items keep coming, so the input stalls
        if (n == 100 && phase != 1) rx_hold_cycles = 300;
        send_random();
      end
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/idwl_pkg.sv
rtl/idwl_seq.sv
rtl/idwl_dp.sv
rtl/id_whitelist_table.sv
tb/id_whitelist_table_tb.sv
